// ===== rtl/lkvc_pkg.sv =====
// ============================================================================
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ============================================================================
package lkvc_pkg;

  // Number of entries in the cell row
  localparam int CAPACITY = 4;
  // Width of a recency rank (at least one bit)
  localparam int AGE_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;

  // Rank held by the least recent entry of a full cache
  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(CAPACITY - 1);

  // Operation codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef logic signed [KEY_W-1:0]  key_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [AGE_W-1:0]         age_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic  wr_en;    // accepted write transaction
    logic  hit_any;  // key present somewhere in the row
    age_t  hit_age;  // rank of the matching entry
    logic  full;     // no free cell in the row
    key_t  key;
    data_t data;
  } cell_ctrl_t;

  // Information rippled from cell to cell along the row
  typedef struct packed {
    logic  free_seen;  // a lower-index cell is free
    logic  hit;        // a lower-index cell matched
    age_t  hit_age;
    data_t value;      // value of the matching cell
    key_t  victim_key; // key of the least recent cell
  } cell_chain_t;

endpackage

// ===== rtl/lkvc_if.sv =====
// ============================================================================
// lkvc_in_if / lkvc_out_if
// Valid/ready channels carrying command and result transactions.
// ============================================================================
interface lkvc_in_if;
  import lkvc_pkg::*;

  logic  valid;
  logic  ready;
  logic  cmd;
  key_t  key;
  data_t data_in;

  modport source (output valid, output cmd, output key, output data_in, input ready);
  modport sink   (input valid, input cmd, input key, input data_in, output ready);
endinterface

interface lkvc_out_if;
  import lkvc_pkg::*;

  logic  valid;
  logic  ready;
  logic  hit;
  data_t data_out;
  logic  evicted;
  key_t  evicted_key;

  modport source (output valid, output hit, output data_out, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input data_out, input evicted,
                  input evicted_key, output ready);
endinterface

// ===== rtl/lru_key_value_cache_unit.sv =====
// ============================================================================
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-written replacement.
// ============================================================================
// One transaction is taken per clock cycle and its result appears in the
// output register on the next cycle; a stalled output holds the input off
// only while that register is full and not being taken. The rate is set by
// the row of entry cells: all cells compare the key, and the hit, value and
// victim information ripples through the row combinationally. Reset clears
// every entry to invalid at once, and no transaction is taken while reset
// is asserted.
// ============================================================================
module lru_key_value_cache_unit (
  input logic      clk,
  input logic      rst_n,
  lkvc_in_if.sink  in_chan,
  lkvc_out_if.source out_chan
);
  import lkvc_pkg::*;

  cell_ctrl_t  ctrl;
  cell_chain_t chain [CAPACITY+1];
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] oldest_vec;

  logic  in_acc;
  logic  out_valid_r, out_valid_nxt;
  logic  hit_r, hit_nxt;
  data_t data_r, data_nxt;
  logic  evicted_r, evicted_nxt;
  key_t  evkey_r, evkey_nxt;

  // Handshake
  assign in_chan.ready = rst_n && (!out_valid_r || out_chan.ready);
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Broadcast to the cells
  assign chain[0] = '0;
  always_comb begin
    ctrl.wr_en   = in_acc && (in_chan.cmd == CMD_WRITE);
    ctrl.hit_any = chain[CAPACITY].hit;
    ctrl.hit_age = chain[CAPACITY].hit_age;
    ctrl.full    = !chain[CAPACITY].free_seen;
    ctrl.key     = in_chan.key;
    ctrl.data    = in_chan.data_in;
  end

  // Row of entry cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lkvc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .chain_in (chain[g]),
      .chain_out(chain[g+1]),
      .match    (match_vec[g]),
      .oldest   (oldest_vec[g])
    );
  end

  // Result formation
  always_comb begin
    out_valid_nxt = out_valid_r;
    hit_nxt       = hit_r;
    data_nxt      = data_r;
    evicted_nxt   = evicted_r;
    evkey_nxt     = evkey_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      hit_nxt       = chain[CAPACITY].hit;
      data_nxt      = '0;
      evicted_nxt   = 1'b0;
      evkey_nxt     = '0;
      if (in_chan.cmd == CMD_READ) begin
        if (chain[CAPACITY].hit) begin
          data_nxt = chain[CAPACITY].value;
        end
      end else if (!chain[CAPACITY].hit && ctrl.full) begin
        evicted_nxt = 1'b1;
        evkey_nxt   = chain[CAPACITY].victim_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r     <= hit_nxt;
    data_r    <= data_nxt;
    evicted_r <= evicted_nxt;
    evkey_r   <= evkey_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.hit         = hit_r;
  assign out_chan.data_out    = data_r;
  assign out_chan.evicted     = evicted_r;
  assign out_chan.evicted_key = evkey_r;

  // Checks
  // A key is held by at most one entry
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("key matched in more than one entry");

  // A full row has exactly one least recent entry
  a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.full |-> $onehot(oldest_vec))
    else $error("full cache without a unique least recent entry");

  // A write miss on a full row reports an eviction
  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.wr_en && !ctrl.hit_any && ctrl.full) |=> (out_valid_r && evicted_r))
    else $error("eviction not reported");

  // Eviction never comes with a hit
  a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && evicted_r) |-> !hit_r)
    else $error("eviction reported on a hit");

  // Non-zero read data only on a hit
  a_data_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (data_r != '0)) |-> hit_r)
    else $error("data returned without a hit");

endmodule

// ===== rtl/lkvc_cell.sv =====
// ============================================================================
// lkvc_cell
// One cache entry: key, value, valid flag and recency rank, with compare
// and ripple logic towards its neighbour.
// ============================================================================
module lkvc_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lkvc_pkg::cell_ctrl_t ctrl,
  input  lkvc_pkg::cell_chain_t chain_in,
  output lkvc_pkg::cell_chain_t chain_out,
  output logic                 match,
  output logic                 oldest
);
  import lkvc_pkg::*;

  logic  valid_r, valid_nxt;
  age_t  age_r, age_nxt;
  key_t  key_r, key_nxt;
  data_t value_r, value_nxt;
  logic  chosen;

  // Compare against the broadcast key
  assign match  = valid_r && (key_r == ctrl.key);
  assign oldest = valid_r && (age_r == AGE_OLDEST);

  // Ripple to the next cell
  always_comb begin
    chain_out.free_seen  = chain_in.free_seen | ~valid_r;
    chain_out.hit        = chain_in.hit | match;
    chain_out.hit_age    = match ? age_r : chain_in.hit_age;
    chain_out.value      = match ? value_r : chain_in.value;
    chain_out.victim_key = oldest ? key_r : chain_in.victim_key;
  end

  // New key lands here: lowest free cell, or the least recent when full
  assign chosen = (!valid_r && !chain_in.free_seen) || (ctrl.full && oldest);

  // Entry update on a write
  always_comb begin
    valid_nxt = valid_r;
    age_nxt   = age_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.wr_en) begin
      if (ctrl.hit_any) begin
        if (match) begin
          value_nxt = ctrl.data;
          age_nxt   = '0;
        end else if (valid_r && (age_r < ctrl.hit_age)) begin
          age_nxt = age_r + AGE_W'(1);
        end
      end else if (chosen) begin
        valid_nxt = 1'b1;
        key_nxt   = ctrl.key;
        value_nxt = ctrl.data;
        age_nxt   = '0;
      end else if (valid_r) begin
        age_nxt = age_r + AGE_W'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

// ===== sim/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for lru_key_value_cache_unit. Command transactions are
// queued by a stimulus process and driven by a clocked driver. A clocked
// monitor predicts each result at input acceptance and compares every
// result transaction with the oldest prediction. A short directed sequence
// covers field extremes, hits, misses and evictions. It is followed by
// random traffic over small key pools under changing backpressure.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lkvc_pkg::*;

  typedef struct {
    logic  cmd;
    key_t  key;
    data_t data;
  } access_t;

  typedef struct {
    logic  hit;
    data_t data_out;
    logic  evicted;
    key_t  evicted_key;
  } lookup_result_t;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int KEY_POOL_MAX     = 16;

  logic clk = 1'b0;
  logic rst_n;

  lkvc_in_if  in_if ();
  lkvc_out_if out_if ();

  lru_key_value_cache_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Stimulus and prediction state
  access_t        access_q[$];
  lookup_result_t lookup_results_q[$];
  access_t        drive_item;
  access_t        seen_access;
  lookup_result_t oldest_exp;
  key_t           key_pool[KEY_POOL_MAX];
  int             issued_cnt   = 0;
  int             retired_cnt  = 0;
  int             mismatch_cnt = 0;
  int             cycle_cnt    = 0;
  int             src_idle_pct = 0;
  int             snk_idle_pct = 0;
  int             hold_cnt     = 0;
  logic           long_hold_req = 1'b0;
  logic           in_taken      = 1'b0;

  // Shadow copy of the cache contents
  logic  cache_valid[CAPACITY];
  key_t  cache_key[CAPACITY];
  data_t cache_value[CAPACITY];
  int    cache_age[CAPACITY];

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[lru_key_value_cache_unit] ERROR");
      $finish;
    end
  end

  // Slot becomes the most recent; younger valid entries below limit age by one
  function automatic void make_most_recent(input int slot, input int limit);
    for (int i = 0; i < CAPACITY; i++)
      if (i != slot && cache_valid[i] && cache_age[i] < limit)
        cache_age[i]++;
    cache_age[slot] = 0;
  endfunction

  // Apply one command to the shadow cache and return the expected result
  function automatic lookup_result_t cache_access_result(input access_t a);
    lookup_result_t r;
    int found;
    int slot;
    int oldest;
    r.hit         = 1'b0;
    r.data_out    = '0;
    r.evicted     = 1'b0;
    r.evicted_key = '0;
    found = -1;
    for (int i = 0; i < CAPACITY; i++)
      if (found < 0 && cache_valid[i] && cache_key[i] == a.key)
        found = i;
    if (found >= 0)
      r.hit = 1'b1;
    if (a.cmd == CMD_READ) begin
      if (found >= 0)
        r.data_out = cache_value[found];
    end else if (found >= 0) begin
      cache_value[found] = a.data;
      make_most_recent(found, cache_age[found]);
    end else begin
      slot = -1;
      for (int i = 0; i < CAPACITY; i++)
        if (slot < 0 && !cache_valid[i])
          slot = i;
      // Full: the least recent entry makes room
      if (slot < 0) begin
        oldest = -1;
        for (int i = 0; i < CAPACITY; i++)
          if (cache_age[i] >= oldest) begin
            oldest = cache_age[i];
            slot   = i;
          end
        r.evicted     = 1'b1;
        r.evicted_key = cache_key[slot];
      end
      cache_valid[slot] = 1'b1;
      cache_key[slot]   = a.key;
      cache_value[slot] = a.data;
      make_most_recent(slot, CAPACITY);
    end
    return r;
  endfunction

  // Driver: presents queued commands, holds each until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (access_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        drive_item = access_q.pop_front();
        in_if.valid   <= 1'b1;
        in_if.cmd     <= drive_item.cmd;
        in_if.key     <= drive_item.key;
        in_if.data_in <= drive_item.data;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_cnt      = LONG_HOLD_CYCLES;
      long_hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Monitor: check result transactions, then predict accepted commands
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (lookup_results_q.size() == 0) begin
          $error("unexpected result: hit %0b data_out %h evicted %0b evicted_key %h",
                 out_if.hit, out_if.data_out, out_if.evicted, out_if.evicted_key);
          mismatch_cnt++;
        end else begin
          oldest_exp = lookup_results_q.pop_front();
          if (out_if.hit !== oldest_exp.hit) begin
            $error("hit: expected %0b, got %0b", oldest_exp.hit, out_if.hit);
            mismatch_cnt++;
          end
          if (out_if.data_out !== oldest_exp.data_out) begin
            $error("data_out: expected %h, got %h", oldest_exp.data_out, out_if.data_out);
            mismatch_cnt++;
          end
          if (out_if.evicted !== oldest_exp.evicted) begin
            $error("evicted: expected %0b, got %0b", oldest_exp.evicted, out_if.evicted);
            mismatch_cnt++;
          end
          if (out_if.evicted_key !== oldest_exp.evicted_key) begin
            $error("evicted_key: expected %h, got %h",
                   oldest_exp.evicted_key, out_if.evicted_key);
            mismatch_cnt++;
          end
        end
        retired_cnt++;
      end
      in_taken = in_if.valid && in_if.ready;
      if (in_taken) begin
        seen_access.cmd  = in_if.cmd;
        seen_access.key  = in_if.key;
        seen_access.data = in_if.data_in;
        lookup_results_q.push_back(cache_access_result(seen_access));
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  task automatic queue_access(input logic cmd, input key_t key, input data_t data);
    access_t a;
    a.cmd  = cmd;
    a.key  = key;
    a.data = data;
    access_q.push_back(a);
    issued_cnt++;
  endtask

  // Mostly keys from a small pool so that hits and evictions stay frequent
  task automatic queue_random_accesses(input int n, input int pool_n);
    key_t k;
    for (int i = 0; i < pool_n; i++)
      key_pool[i] = key_t'($urandom);
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(99) < 80)
        k = key_pool[$urandom_range(pool_n - 1)];
      else
        k = key_t'($urandom);
      queue_access(($urandom_range(99) < 40) ? CMD_READ : CMD_WRITE, k,
                   data_t'($urandom));
    end
  endtask

  // Sender pause: wait until every queued transaction has produced its result
  task automatic wait_for_drain();
    while (retired_cnt != issued_cnt)
      @(negedge clk);
    @(posedge clk);
  endtask

  // Stimulus sequence
  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.cmd     = CMD_WRITE;
    in_if.key     = '0;
    in_if.data_in = '0;
    out_if.ready  = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      cache_valid[i] = 1'b0;
      cache_key[i]   = '0;
      cache_value[i] = '0;
      cache_age[i]   = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 12;
    snk_idle_pct = 85;

    // Directed: empty-cache miss, extremes, refresh when full, evictions
    queue_access(CMD_READ,  key_t'(32'h0000_0000), data_t'(32'hFFFF_FFFF));
    queue_access(CMD_WRITE, key_t'(32'h8000_0000), data_t'(32'h7FFF_FFFF));
    queue_access(CMD_WRITE, key_t'(32'h7FFF_FFFF), data_t'(32'h8000_0000));
    queue_access(CMD_WRITE, key_t'(32'h0000_0000), data_t'(32'h0000_0000));
    queue_access(CMD_WRITE, key_t'(32'hFFFF_FFFF), data_t'(32'hFFFF_FFFF));
    queue_access(CMD_READ,  key_t'(32'h8000_0000), data_t'(32'h0000_0000));
    queue_access(CMD_READ,  key_t'(32'hFFFF_FFFF), data_t'(32'h1234_5678));
    queue_access(CMD_WRITE, key_t'(32'h8000_0000), data_t'(32'h1234_5678));
    queue_access(CMD_WRITE, key_t'(32'h0000_0005), data_t'(32'h0000_0001));
    queue_access(CMD_READ,  key_t'(32'h7FFF_FFFF), data_t'(32'hDEAD_BEEF));
    queue_access(CMD_WRITE, key_t'(32'h0000_0000), data_t'(32'h5555_5555));
    queue_access(CMD_WRITE, key_t'(32'h0000_0006), data_t'(32'h0000_0002));
    queue_access(CMD_WRITE, key_t'(32'h0000_0007), data_t'(32'h0000_0003));
    queue_access(CMD_READ,  key_t'(32'h0000_0005), data_t'(32'h0000_0000));
    queue_access(CMD_READ,  key_t'(32'h8000_0000), data_t'(32'h0000_0000));
    queue_access(CMD_WRITE, key_t'(32'h0000_0008), data_t'(32'h0000_0004));
    queue_access(CMD_WRITE, key_t'(32'hAAAA_AAAA), data_t'(32'hAAAA_AAAA));
    queue_access(CMD_READ,  key_t'(32'hAAAA_AAAA), data_t'(32'h0000_0000));
    queue_access(CMD_WRITE, key_t'(32'hAAAA_AAAA), data_t'(32'h5555_5555));
    queue_access(CMD_WRITE, key_t'(32'h0000_0006), data_t'(32'h0000_0000));
    queue_access(CMD_WRITE, key_t'(32'h5555_5555), data_t'(32'hFFFF_FFFF));
    wait_for_drain();

    // Random: sender mostly busy, receiver mostly stalled
    queue_random_accesses(300, 6);
    wait_for_drain();

    // Random: sender mostly idle, receiver mostly ready
    src_idle_pct = 85;
    snk_idle_pct = 12;
    queue_random_accesses(300, 5);
    wait_for_drain();

    // Random at full rate, opening with a long receiver hold-off
    src_idle_pct  = 0;
    snk_idle_pct  = 0;
    long_hold_req = 1'b1;
    queue_random_accesses(300, 8);
    wait_for_drain();

    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0 && lookup_results_q.size() == 0) begin
      $display("[lru_key_value_cache_unit] OK");
    end else begin
      $display("[lru_key_value_cache_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lkvc_pkg.sv
rtl/lkvc_if.sv
rtl/lkvc_cell.sv
rtl/lru_key_value_cache_unit.sv
sim/tb_top.sv
